// ===== design/slab_object_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// slab object allocator assertion macros
// concurrent checks on clk_i, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check outside reset
`define SOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check at every edge, reset included
`define SOA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SOA_ASSERT(lbl, prop, msg)
`define SOA_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== design/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// soa_pkg
// shared constants, codes and controller/datapath types of the slab allocator
// ----------------------------------------------------------------------------
`default_nettype none

package soa_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int POOL_PAGES = 20;
  localparam int FREE_DEPTH = 64;

  localparam int ADDR_W    = 32;
  localparam int LOG2_W    = 4;
  localparam int BASE_W    = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 1;
  localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
  localparam int PTR_W     = $clog2(FREE_DEPTH);
  localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
  localparam int TAKEN_W   = $clog2(POOL_PAGES + 1);
  localparam int LEFT_W    = PAGE_LOG2;
  localparam int PFN_W     = BASE_W + 1;

  localparam logic [LOG2_W-1:0] ITEM_LOG2_RST = LOG2_W'(4);
  localparam logic [BASE_W-1:0] POOL_BASE_RST = '0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_SIZE_LOG2 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE_PAGE = 1'b1;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_QFULL = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    exec;     // request accepted this cycle
    logic    push;     // write free address into the queue
    logic    pop;      // read oldest queue entry
    logic    bump;     // hand out next slot of the open page
    status_e status;   // result code of the request
    logic    load_out; // load output register
    logic    wb_pop;   // output address comes from queue read data
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_empty;
    logic q_full;
    logic page_open;
    logic pool_spent;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/slab_object_allocator_core.sv =====
// ----------------------------------------------------------------------------
// slab_object_allocator_core
// fixed-size object allocator for one cache, free queue plus page bump pointer
// ----------------------------------------------------------------------------
// usage
//   requests arrive on the s_axis channel: tuser is the kind (allocate or
//   free), tdata the address to free. every accepted request yields exactly
//   one transfer on m_axis: tuser the status (ok, out of memory, queue full),
//   tdata the allocated address, zero on free or error.
//   allocate pops the oldest freed address first, else bump-allocates the
//   open page, else opens the next pool page.
//   a request is decoded at accept and its result moved into the output
//   register by the writeback state; no new request is taken before that
//   writeback, as the free queue memory has a registered read.
//   the output register frees the request side: a new request is taken
//   while a finished result still waits on a stalled receiver; only the
//   writeback of the following result waits for the register to drain.
//   reset clears queue pointers, page state and output valid, and loads the
//   item size and pool base registers with their defaults. no clearing pass.
//   configuration writes via cfg_we_i take effect from the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module slab_object_allocator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [soa_pkg::ADDR_W-1:0]    s_axis_tdata,  // [31:0] free_addr
  input  wire logic                          s_axis_tuser,  // [0] op
  // result channel
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [soa_pkg::ADDR_W-1:0]         m_axis_tdata,  // [31:0] addr
  output logic [1:0]                         m_axis_tuser,  // [1:0] status
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [soa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [soa_pkg::CFG_W-1:0]     cfg_data_i
);
  import soa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: decode at accept, writeback into the output register
  soa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and address arithmetic
  soa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .free_addr_i (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .status_o    (m_axis_tuser),
    .addr_o      (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== design/soa_ctrl.sv =====
// ----------------------------------------------------------------------------
// soa_ctrl
// request decode, sequencing and output valid of the slab allocator
// ----------------------------------------------------------------------------
`default_nettype none
`include "slab_object_allocator_core_assert.svh"

module soa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          op_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire soa_pkg::sts_t sts_i,
  output soa_pkg::cmd_t      cmd_o
);
  import soa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WB   = 1'b1;

  logic   state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   pop_q;
  logic   accept;
  cmd_t   cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    cmd          = '0;
    cmd.status   = ST_OK;
    cmd.wb_pop   = pop_q;
    cmd.load_out = (state_q == S_WB) && (!out_valid_q || out_ready_i);
    if (accept) begin
      cmd.exec = 1'b1;
      if (op_i == OP_FREE) begin
        if (sts_i.q_full) begin
          cmd.status = ST_QFULL;
        end else begin
          cmd.push = 1'b1;
        end
      end else if (!sts_i.q_empty) begin
        cmd.pop = 1'b1;
      end else if (!sts_i.page_open && sts_i.pool_spent) begin
        cmd.status = ST_OOM;
      end else begin
        cmd.bump = 1'b1;
      end
    end
  end

  assign cmd_o = cmd;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_WB;
      end
      S_WB: begin
        if (cmd.load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pop_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) pop_q <= cmd.pop;
    end
  end

  assign out_valid_o = out_valid_q;

  `SOA_ASSERT(a_accept_to_wb, accept |=> (state_q == S_WB), "accept did not enter writeback")
  `SOA_ASSERT(a_load_sets_valid, cmd.load_out |=> out_valid_q, "output load lost")
  `SOA_ASSERT(a_stall_holds_wb, (state_q == S_WB && out_valid_q && !out_ready_i) |=> (state_q == S_WB), "result dropped while stalled")

endmodule

`default_nettype wire

// ===== design/soa_datapath.sv =====
// ----------------------------------------------------------------------------
// soa_datapath
// free queue memory, page bump pointer, configuration and output registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "slab_object_allocator_core_assert.svh"

module soa_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire soa_pkg::cmd_t                     cmd_i,
  input  wire logic [soa_pkg::ADDR_W-1:0]        free_addr_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [soa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [soa_pkg::CFG_W-1:0]         cfg_data_i,
  output soa_pkg::sts_t                          sts_o,
  output logic [1:0]                             status_o,
  output logic [soa_pkg::ADDR_W-1:0]             addr_o
);
  import soa_pkg::*;

  logic [LOG2_W-1:0]  log2_q;
  logic [BASE_W-1:0]  base_q;

  logic [ADDR_W-1:0]  mem [FREE_DEPTH];
  logic [ADDR_W-1:0]  rd_q;
  logic [PTR_W-1:0]   head_q, tail_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [TAKEN_W-1:0] taken_q;
  logic               open_q;
  logic [ADDR_W-1:0]  bump_q;
  logic [LEFT_W-1:0]  left_q;

  logic [ADDR_W-1:0]  res_addr_q;
  status_e            res_status_q;
  logic [ADDR_W-1:0]  out_addr_q;
  status_e            out_status_q;

  logic [LEFT_W-1:0]  ipp_m1;
  logic [LEFT_W-1:0]  left_eff;
  logic [TAKEN_W-1:0] taken_idx;
  logic [PFN_W-1:0]   pfn;
  logic [ADDR_W-1:0]  page_addr;
  logic [ADDR_W-1:0]  off_use;
  logic [ADDR_W-1:0]  bump_addr;
  logic [ADDR_W-1:0]  step;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(FREE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q <= ITEM_LOG2_RST;
      base_q <= POOL_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ITEM_SIZE_LOG2: log2_q <= cfg_data_i[LOG2_W-1:0];
        REG_POOL_BASE_PAGE: base_q <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // page geometry, slots per page minus one (one slot when item exceeds page)
  always_comb begin
    if (32'(log2_q) >= PAGE_LOG2) begin
      ipp_m1 = '0;
    end else begin
      ipp_m1 = LEFT_W'((PAGE_BYTES >> log2_q) - 1);
    end
  end

  assign left_eff  = open_q ? left_q : ipp_m1;
  assign taken_idx = open_q ? taken_q - TAKEN_W'(1) : taken_q;
  assign pfn       = PFN_W'(base_q) + PFN_W'(taken_idx);
  assign page_addr = ADDR_W'({pfn, {PAGE_LOG2{1'b0}}});
  assign off_use   = open_q ? bump_q : '0;
  assign bump_addr = page_addr + off_use;
  assign step      = ADDR_W'(1) << log2_q;

  // free queue storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem[tail_q] <= free_addr_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      taken_q <= '0;
      open_q  <= 1'b0;
      bump_q  <= '0;
      left_q  <= '0;
    end else begin
      if (cmd_i.push) begin
        tail_q <= next_ptr(tail_q);
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.pop) begin
        head_q <= next_ptr(head_q);
        cnt_q  <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.bump) begin
        if (!open_q) taken_q <= taken_q + TAKEN_W'(1);
        if (left_eff == '0) begin
          open_q <= 1'b0;
          bump_q <= '0;
        end else begin
          open_q <= 1'b1;
          left_q <= left_eff - LEFT_W'(1);
          bump_q <= off_use + step;
        end
      end
    end
  end

  // result and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_addr_q   <= cmd_i.bump ? bump_addr : '0;
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.load_out) begin
      out_addr_q   <= cmd_i.wb_pop ? rd_q : res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign status_o = out_status_q;
  assign addr_o   = out_addr_q;

  assign sts_o.q_empty    = (cnt_q == '0);
  assign sts_o.q_full     = (cnt_q == CNT_W'(FREE_DEPTH));
  assign sts_o.page_open  = open_q;
  assign sts_o.pool_spent = (taken_q >= TAKEN_W'(POOL_PAGES));

  `SOA_ASSERT_NR(a_cnt_bound, cnt_q <= CNT_W'(FREE_DEPTH), "free queue count overflow")
  `SOA_ASSERT(a_ptr_cnt, ((int'(tail_q) - int'(head_q) + FREE_DEPTH) % FREE_DEPTH) == (int'(cnt_q) % FREE_DEPTH), "queue pointers disagree with count")
  `SOA_ASSERT(a_open_taken, (!open_q || (taken_q != '0)) && (taken_q <= TAKEN_W'(POOL_PAGES)), "page state inconsistent")

endmodule

`default_nettype wire
